// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define IMB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IMB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/imb_pkg.sv
package imb_pkg;

	localparam int VERTEX_DEPTH = 1024;
	localparam int FACE_DEPTH   = 2048;
	localparam int VIDX_W       = 10;
	localparam int FIDX_W       = 11;
	localparam int VCNT_W       = 11;
	localparam int FCNT_W       = 12;
	localparam int COORD_W      = 32;
	localparam int RAD_W        = 31;
	localparam int OUT_W        = 152;

	// 1/sqrt(phi^2+1) and phi/sqrt(phi^2+1) in unsigned Q0.32
	localparam logic [31:0] KA_Q32 = 32'd2257997933;
	localparam logic [31:0] KB_Q32 = 32'd3653517402;

	localparam logic [1:0] REQ_BUILD     = 2'd0;
	localparam logic [1:0] REQ_READ_VERT = 2'd1;
	localparam logic [1:0] REQ_READ_FACE = 2'd2;
	localparam logic [1:0] REQ_NOP       = 2'd3;

	localparam logic [1:0] ERR_OK          = 2'd0;
	localparam logic [1:0] ERR_ZERO_RADIUS = 2'd1;
	localparam logic [1:0] ERR_FULL        = 2'd2;
	localparam logic [1:0] ERR_RANGE       = 2'd3;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_LEVELS = 1'b1;

	typedef logic signed [2:0] ico_coord_t;

	// unit-less icosahedron corners: +-1 selects A, +-2 selects B
	localparam ico_coord_t ICO_VERT [12][3] = '{
		'{-3'sd1,  3'sd0,  3'sd2}, '{ 3'sd1,  3'sd0,  3'sd2},
		'{-3'sd1,  3'sd0, -3'sd2}, '{ 3'sd1,  3'sd0, -3'sd2},
		'{ 3'sd0,  3'sd2,  3'sd1}, '{ 3'sd0,  3'sd2, -3'sd1},
		'{ 3'sd0, -3'sd2,  3'sd1}, '{ 3'sd0, -3'sd2, -3'sd1},
		'{ 3'sd2,  3'sd1,  3'sd0}, '{-3'sd2,  3'sd1,  3'sd0},
		'{ 3'sd2, -3'sd1,  3'sd0}, '{-3'sd2, -3'sd1,  3'sd0}
	};

	localparam logic [3:0] ICO_FACE [20][3] = '{
		'{4'd0, 4'd4, 4'd1},  '{4'd0, 4'd9, 4'd4},   '{4'd9, 4'd5, 4'd4},
		'{4'd4, 4'd5, 4'd8},  '{4'd4, 4'd8, 4'd1},   '{4'd8, 4'd10, 4'd1},
		'{4'd8, 4'd3, 4'd10}, '{4'd5, 4'd3, 4'd8},   '{4'd5, 4'd2, 4'd3},
		'{4'd2, 4'd7, 4'd3},  '{4'd7, 4'd10, 4'd3},  '{4'd7, 4'd6, 4'd10},
		'{4'd7, 4'd11, 4'd6}, '{4'd11, 4'd0, 4'd6},  '{4'd0, 4'd1, 4'd6},
		'{4'd6, 4'd1, 4'd10}, '{4'd9, 4'd0, 4'd11},  '{4'd9, 4'd11, 4'd2},
		'{4'd9, 4'd2, 4'd5},  '{4'd7, 4'd2, 4'd11}
	};

	function automatic logic [31:0] ico_comp(input ico_coord_t s, input logic [31:0] ca,
			input logic [31:0] cb);
		logic [31:0] mag;
		if (s == 3'sd1 || s == -3'sd1) begin
			mag = ca;
		end else if (s == 3'sd0) begin
			mag = 32'd0;
		end else begin
			mag = cb;
		end
		return (s < 3'sd0) ? (32'd0 - mag) : mag;
	endfunction

endpackage

// File: rtl/icosphere_mesh_builder_unit.sv
// channel   dir  tvalid/tready   payload
// s_axis    in   request         tuser: req_type[1:0]; tdata: entry_index[10:0]
// m_axis    out  result          tdata: coords, corners, totals, error_code
// cfg       in   write only      cfg_addr 0 radius, 1 level count
//
// A build seeds the solid, then computes the edge midpoints: the serial
// multiplier, the 2-bit-a-step root and the 1-bit-a-step divider share one
// sequencer and the duplicate scan reads the vertex memory once a cycle.
// arst_n clears counts and control and sets radius 65536, level count 0;
// the stores are not cleared. A new request is taken while a finished result
// waits on m_axis.
module icosphere_mesh_builder_unit import imb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // entry_index[10:0], zero pad
	input  logic [1:0]           s_axis_tuser,  // req_type[1:0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// coord_x, coord_y, coord_z, corner_first, corner_second, corner_third,
	// vertex_total, face_total, error_code, zero pad
	output logic [OUT_W-1:0]     m_axis_tdata,
	input  logic                 cfg_we,
	input  logic                 cfg_addr,
	input  logic [RAD_W-1:0]     cfg_wdata
);

	typedef enum logic [19:0] {
		ST_IDLE      = 20'h00001,
		ST_RD_WAIT   = 20'h00002,
		ST_BLD_MUL_A = 20'h00004,
		ST_BLD_MUL_B = 20'h00008,
		ST_BLD_VERT  = 20'h00010,
		ST_BLD_FACE  = 20'h00020,
		ST_FACE_RD   = 20'h00040,
		ST_FACE_CAP  = 20'h00080,
		ST_MID_RDP   = 20'h00100,
		ST_MID_RDQ   = 20'h00200,
		ST_MID_SUM   = 20'h00400,
		ST_MID_SQ    = 20'h00800,
		ST_MID_SQRT  = 20'h01000,
		ST_MID_LEN   = 20'h02000,
		ST_MID_MUL   = 20'h04000,
		ST_MID_DIV   = 20'h08000,
		ST_MID_SCAN  = 20'h10000,
		ST_MID_ADD   = 20'h20000,
		ST_FACE_WR   = 20'h40000,
		ST_RESP      = 20'h80000
	} state_t;

	state_t state_q;

	logic [95:0]  vmem [VERTEX_DEPTH];
	logic [29:0]  fmem [FACE_DEPTH];
	logic [95:0]  vrdata_q;
	logic [29:0]  frdata_q;
	logic         vwe, fwe;
	logic [VIDX_W-1:0] vraddr, vwaddr;
	logic [FIDX_W-1:0] fraddr, fwaddr;
	logic [95:0]  vwdata;
	logic [29:0]  fwdata;

	logic [RAD_W-1:0]  radius_q;
	logic [1:0]        levels_q;
	logic [VCNT_W-1:0] vcount_q;
	logic [FCNT_W-1:0] fcount_q;

	logic [1:0]        req_q;
	logic [FIDX_W-1:0] idx_q;
	logic [1:0]        err_q;
	logic [2:0][31:0]  res_v_q;
	logic [2:0][9:0]   res_f_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [6:0]  cnt_q;
	logic [1:0]  k_q;
	logic [1:0]  mid_sel_q;
	logic [1:0]  lvl_q;
	logic [1:0]  fw_q;
	logic [FIDX_W-1:0] face_i_q;
	logic [FCNT_W-1:0] nf_q;
	logic [9:0]  a_q, b_q, c_q, ab_q, bc_q, ac_q;
	logic [31:0] ca_q, cb_q;
	logic [95:0] pv_q;
	logic [2:0][31:0] mag_q;
	logic [2:0]  neg_q;
	logic [63:0] n2_q;
	logic [2:0][31:0] v_q;

	logic [63:0] mul_a_q, mul_acc_q, mul_next;
	logic [31:0] mul_b_q;
	logic [63:0] sq_n_q;
	logic [33:0] sq_rem_q;
	logic [35:0] sq_rem2, sq_trial;
	logic        sq_ge;
	logic [31:0] len_q;
	logic [63:0] div_n_q;
	logic [31:0] div_rem_q;
	logic [32:0] div_rem2;
	logic        div_ge;
	logic [31:0] div_quo;

	logic [VCNT_W-1:0] scan_q;
	logic              chk_s1;
	logic [VIDX_W-1:0] idx_s1;

	logic [9:0]       pidx, qidx;
	logic [2:0][31:0] mag_c;
	logic [2:0]       neg_c;
	logic             mid_done;
	logic [9:0]       mid_idx;
	logic             s_acc;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// edge pairs in order ab, cb, ac
	assign pidx = (mid_sel_q == 2'd1) ? c_q : a_q;
	assign qidx = (mid_sel_q == 2'd2) ? c_q : b_q;

	always_comb begin
		logic [32:0] s;
		logic [32:0] r;
		logic [31:0] m;
		for (int k = 0; k < 3; k++) begin
			s = {pv_q[32*k+31], pv_q[32*k +: 32]} + {vrdata_q[32*k+31], vrdata_q[32*k +: 32]};
			// halve, truncating toward zero
			r = s + {32'd0, s[32]};
			m = r[32:1];
			neg_c[k] = m[31];
			mag_c[k] = m[31] ? (32'd0 - m) : m;
		end
	end

	assign mul_next = mul_acc_q + (mul_b_q[0] ? mul_a_q : 64'd0);
	assign sq_rem2  = {sq_rem_q, sq_n_q[63:62]};
	assign sq_trial = {2'b00, len_q, 2'b01};
	assign sq_ge    = (sq_rem2 >= sq_trial);
	assign div_rem2 = {div_rem_q, div_n_q[63]};
	assign div_ge   = (div_rem2 >= {1'b0, len_q});
	assign div_quo  = {div_n_q[30:0], div_ge};

	assign mid_done = (state_q == ST_MID_SCAN && chk_s1 && vrdata_q == v_q) ||
		(state_q == ST_MID_ADD && vcount_q != VCNT_W'(VERTEX_DEPTH));
	assign mid_idx  = (state_q == ST_MID_ADD) ? vcount_q[VIDX_W-1:0] : idx_s1;

	always_comb begin
		vraddr = scan_q[VIDX_W-1:0];
		fraddr = face_i_q;
		case (state_q)
			ST_IDLE: begin
				vraddr = s_axis_tdata[VIDX_W-1:0];
				fraddr = s_axis_tdata[FIDX_W-1:0];
			end
			ST_MID_RDP: vraddr = pidx;
			ST_MID_RDQ: vraddr = qidx;
			default: ;
		endcase
	end

	always_comb begin
		vwe    = 1'b0;
		vwaddr = vcount_q[VIDX_W-1:0];
		vwdata = v_q;
		fwe    = 1'b0;
		fwaddr = face_i_q;
		fwdata = {ac_q, bc_q, ab_q};
		case (state_q)
			ST_BLD_VERT: begin
				vwe    = 1'b1;
				vwaddr = VIDX_W'(cnt_q[3:0]);
				vwdata = {ico_comp(ICO_VERT[cnt_q[3:0]][2], ca_q, cb_q),
					ico_comp(ICO_VERT[cnt_q[3:0]][1], ca_q, cb_q),
					ico_comp(ICO_VERT[cnt_q[3:0]][0], ca_q, cb_q)};
			end
			ST_MID_ADD: vwe = (vcount_q != VCNT_W'(VERTEX_DEPTH));
			ST_BLD_FACE: begin
				fwe    = 1'b1;
				fwaddr = FIDX_W'(cnt_q[4:0]);
				fwdata = {6'd0, ICO_FACE[cnt_q[4:0]][2], 6'd0, ICO_FACE[cnt_q[4:0]][1],
					6'd0, ICO_FACE[cnt_q[4:0]][0]};
			end
			ST_FACE_WR: begin
				fwe = (fw_q != 2'd0) ||
					({1'b0, fcount_q} + 13'd3 <= 13'(FACE_DEPTH));
				case (fw_q)
					2'd0: begin
						fwaddr = fcount_q[FIDX_W-1:0];
						fwdata = {ac_q, ab_q, a_q};
					end
					2'd1: begin
						fwaddr = fcount_q[FIDX_W-1:0] + 11'd1;
						fwdata = {bc_q, ab_q, b_q};
					end
					2'd2: begin
						fwaddr = fcount_q[FIDX_W-1:0] + 11'd2;
						fwdata = {ac_q, bc_q, c_q};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwaddr] <= vwdata;
		end
		vrdata_q <= vmem[vraddr];
	end

	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[fwaddr] <= fwdata;
		end
		frdata_q <= fmem[fraddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(32'd65536);
			levels_q <= 2'd0;
		end else if (cfg_we) begin
			if (cfg_addr == REG_RADIUS) begin
				radius_q <= cfg_wdata;
			end else begin
				levels_q <= cfg_wdata[1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {1'b0, err_q, fcount_q, vcount_q, res_f_q, res_v_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			vcount_q    <= '0;
			fcount_q    <= '0;
			chk_s1      <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						req_q   <= s_axis_tuser;
						idx_q   <= s_axis_tdata[FIDX_W-1:0];
						err_q   <= ERR_OK;
						res_v_q <= '0;
						res_f_q <= '0;
						if (s_axis_tuser == REQ_BUILD) begin
							vcount_q <= '0;
							fcount_q <= '0;
							if (radius_q == '0) begin
								err_q   <= ERR_ZERO_RADIUS;
								state_q <= ST_RESP;
							end else begin
								mul_a_q   <= {33'd0, radius_q};
								mul_b_q   <= KA_Q32;
								mul_acc_q <= '0;
								cnt_q     <= 7'd32;
								state_q   <= ST_BLD_MUL_A;
							end
						end else if (s_axis_tuser == REQ_READ_VERT ||
								s_axis_tuser == REQ_READ_FACE) begin
							state_q <= ST_RD_WAIT;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RD_WAIT: begin
					if (req_q == REQ_READ_VERT) begin
						if (idx_q < vcount_q) begin
							res_v_q <= vrdata_q;
						end else begin
							err_q <= ERR_RANGE;
						end
					end else begin
						if ({1'b0, idx_q} < fcount_q) begin
							res_f_q <= frdata_q;
						end else begin
							err_q <= ERR_RANGE;
						end
					end
					state_q <= ST_RESP;
				end
				ST_BLD_MUL_A, ST_BLD_MUL_B: begin
					mul_acc_q <= mul_next;
					mul_a_q   <= {mul_a_q[62:0], 1'b0};
					mul_b_q   <= {1'b0, mul_b_q[31:1]};
					cnt_q     <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						// round half up to Q15.16
						if (state_q == ST_BLD_MUL_A) begin
							ca_q      <= mul_next[63:32] + {31'd0, mul_next[31]};
							mul_a_q   <= {33'd0, radius_q};
							mul_b_q   <= KB_Q32;
							mul_acc_q <= '0;
							cnt_q     <= 7'd32;
							state_q   <= ST_BLD_MUL_B;
						end else begin
							cb_q    <= mul_next[63:32] + {31'd0, mul_next[31]};
							cnt_q   <= '0;
							state_q <= ST_BLD_VERT;
						end
					end
				end
				ST_BLD_VERT: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd11) begin
						vcount_q <= VCNT_W'(12);
						cnt_q    <= '0;
						state_q  <= ST_BLD_FACE;
					end
				end
				ST_BLD_FACE: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd19) begin
						fcount_q <= FCNT_W'(20);
						lvl_q    <= '0;
						face_i_q <= '0;
						nf_q     <= FCNT_W'(20);
						state_q  <= (levels_q == 2'd0) ? ST_RESP : ST_FACE_RD;
					end
				end
				ST_FACE_RD: state_q <= ST_FACE_CAP;
				ST_FACE_CAP: begin
					a_q       <= frdata_q[9:0];
					b_q       <= frdata_q[19:10];
					c_q       <= frdata_q[29:20];
					mid_sel_q <= '0;
					state_q   <= ST_MID_RDP;
				end
				ST_MID_RDP: state_q <= ST_MID_RDQ;
				ST_MID_RDQ: begin
					pv_q    <= vrdata_q;
					state_q <= ST_MID_SUM;
				end
				ST_MID_SUM: begin
					mag_q     <= mag_c;
					neg_q     <= neg_c;
					n2_q      <= '0;
					k_q       <= '0;
					mul_a_q   <= {32'd0, mag_c[0]};
					mul_b_q   <= mag_c[0];
					mul_acc_q <= '0;
					cnt_q     <= 7'd32;
					state_q   <= ST_MID_SQ;
				end
				ST_MID_SQ: begin
					mul_acc_q <= mul_next;
					mul_a_q   <= {mul_a_q[62:0], 1'b0};
					mul_b_q   <= {1'b0, mul_b_q[31:1]};
					cnt_q     <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						n2_q <= n2_q + mul_next;
						if (k_q == 2'd2) begin
							sq_n_q   <= n2_q + mul_next;
							sq_rem_q <= '0;
							len_q    <= '0;
							cnt_q    <= 7'd32;
							state_q  <= ST_MID_SQRT;
						end else begin
							k_q       <= k_q + 2'd1;
							mul_a_q   <= {32'd0, mag_q[k_q + 2'd1]};
							mul_b_q   <= mag_q[k_q + 2'd1];
							mul_acc_q <= '0;
							cnt_q     <= 7'd32;
						end
					end
				end
				ST_MID_SQRT: begin
					// two radicand bits per step
					sq_rem_q <= sq_ge ? 34'(sq_rem2 - sq_trial) : sq_rem2[33:0];
					len_q    <= {len_q[30:0], sq_ge};
					sq_n_q   <= {sq_n_q[61:0], 2'b00};
					cnt_q    <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= ST_MID_LEN;
					end
				end
				ST_MID_LEN: begin
					k_q <= '0;
					if (len_q == '0) begin
						// midpoint at the origin
						v_q     <= '0;
						scan_q  <= '0;
						chk_s1  <= 1'b0;
						state_q <= ST_MID_SCAN;
					end else begin
						mul_a_q   <= {32'd0, mag_q[0]};
						mul_b_q   <= {1'b0, radius_q};
						mul_acc_q <= '0;
						cnt_q     <= 7'd32;
						state_q   <= ST_MID_MUL;
					end
				end
				ST_MID_MUL: begin
					mul_acc_q <= mul_next;
					mul_a_q   <= {mul_a_q[62:0], 1'b0};
					mul_b_q   <= {1'b0, mul_b_q[31:1]};
					cnt_q     <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						div_n_q   <= mul_next + {33'd0, len_q[31:1]};
						div_rem_q <= '0;
						cnt_q     <= 7'd64;
						state_q   <= ST_MID_DIV;
					end
				end
				ST_MID_DIV: begin
					div_rem_q <= div_ge ? 32'(div_rem2 - {1'b0, len_q}) : div_rem2[31:0];
					div_n_q   <= {div_n_q[62:0], div_ge};
					cnt_q     <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						v_q[k_q] <= neg_q[k_q] ? (32'd0 - div_quo) : div_quo;
						if (k_q == 2'd2) begin
							scan_q  <= '0;
							chk_s1  <= 1'b0;
							state_q <= ST_MID_SCAN;
						end else begin
							k_q       <= k_q + 2'd1;
							mul_a_q   <= {32'd0, mag_q[k_q + 2'd1]};
							mul_b_q   <= {1'b0, radius_q};
							mul_acc_q <= '0;
							cnt_q     <= 7'd32;
							state_q   <= ST_MID_MUL;
						end
					end
				end
				ST_MID_SCAN: begin
					// read one stored vertex a cycle, compare it in the next cycle
					if (chk_s1 && ({1'b0, idx_s1} + 11'd1 == vcount_q) &&
							vrdata_q != v_q) begin
						chk_s1  <= 1'b0;
						state_q <= ST_MID_ADD;
					end else if (scan_q < vcount_q) begin
						chk_s1 <= 1'b1;
						idx_s1 <= scan_q[VIDX_W-1:0];
						scan_q <= scan_q + 11'd1;
					end else begin
						chk_s1 <= 1'b0;
					end
				end
				ST_MID_ADD: begin
					if (vcount_q == VCNT_W'(VERTEX_DEPTH)) begin
						err_q   <= ERR_FULL;
						state_q <= ST_RESP;
					end else begin
						vcount_q <= vcount_q + 11'd1;
					end
				end
				ST_FACE_WR: begin
					fw_q <= fw_q + 2'd1;
					if (fw_q == 2'd0 && !fwe) begin
						err_q   <= ERR_FULL;
						state_q <= ST_RESP;
					end else if (fw_q == 2'd3) begin
						fcount_q <= fcount_q + 12'd3;
						if ({1'b0, face_i_q} + 12'd1 == nf_q) begin
							if (lvl_q + 2'd1 == levels_q) begin
								state_q <= ST_RESP;
							end else begin
								lvl_q    <= lvl_q + 2'd1;
								nf_q     <= fcount_q + 12'd3;
								face_i_q <= '0;
								state_q  <= ST_FACE_RD;
							end
						end else begin
							face_i_q <= face_i_q + 11'd1;
							state_q  <= ST_FACE_RD;
						end
					end
				end
				ST_RESP: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (mid_done) begin
				chk_s1 <= 1'b0;
				case (mid_sel_q)
					2'd0: ab_q <= mid_idx;
					2'd1: bc_q <= mid_idx;
					default: ac_q <= mid_idx;
				endcase
				if (mid_sel_q == 2'd2) begin
					fw_q    <= '0;
					state_q <= ST_FACE_WR;
				end else begin
					mid_sel_q <= mid_sel_q + 2'd1;
					state_q   <= ST_MID_RDP;
				end
			end
		end
	end

endmodule

// File: rtl/imb_checker.sv
`include "assert_macros.svh"

module imb_checker import imb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	logic [1:0] err;

	assign err = m_axis_tdata[150:149];

	`IMB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`IMB_ASSERT_NEXT(a_req_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
	`IMB_ASSERT_NOW(a_range_zero, m_axis_tvalid && err == ERR_RANGE, m_axis_tdata[125:0] == '0, "out of range read carries data")
	`IMB_ASSERT_NOW(a_radius_empty, m_axis_tvalid && err == ERR_ZERO_RADIUS, m_axis_tdata[148:126] == '0, "zero radius left entries")
	`IMB_ASSERT_NOW(a_totals, m_axis_tvalid, m_axis_tdata[136:126] <= VERTEX_DEPTH && m_axis_tdata[148:137] <= FACE_DEPTH, "totals beyond store depth")

endmodule

bind icosphere_mesh_builder_unit imb_checker u_imb_checker (.*);

// File: test/icosphere_mesh_builder_unit_tb.sv
module icosphere_mesh_builder_unit_tb import imb_pkg::*;;

	localparam int WATCHDOG_LIMIT = 3000000;

	typedef struct packed {
		logic [1:0]  err;
		logic [11:0] ftot;
		logic [10:0] vtot;
		logic [9:0]  c3;
		logic [9:0]  c2;
		logic [9:0]  c1;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} mesh_reply_t;

	class mesh_scoreboard;
		int               vtx[VERTEX_DEPTH][3];
		int unsigned      fc[FACE_DEPTH][3];
		int unsigned      vcount;
		int unsigned      fcount;
		longint unsigned  radius;
		int unsigned      levels;
		mesh_reply_t      pending[$];
		int               mismatches;

		function new();
			vcount = 0;
			fcount = 0;
			radius = 65536;
			levels = 0;
			mismatches = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// find or append the midpoint of p and q pushed out to the radius
		function bit split_edge(int unsigned p, int unsigned q, output int unsigned idx);
			longint m[3];
			longint unsigned mag;
			longint unsigned n2;
			longint unsigned len;
			int v[3];
			n2 = 0;
			for (int k = 0; k < 3; k++) begin
				m[k] = (longint'(vtx[p][k]) + longint'(vtx[q][k])) / 2;
				mag = (m[k] < 0) ? -m[k] : m[k];
				n2 += mag * mag;
			end
			len = int_sqrt(n2);
			for (int k = 0; k < 3; k++) begin
				if (len == 0) begin
					v[k] = 0;
				end else begin
					mag = (m[k] < 0) ? -m[k] : m[k];
					mag = (mag * radius + len / 2) / len;
					v[k] = (m[k] < 0) ? -int'(mag) : int'(mag);
				end
			end
			for (int k = 0; k < vcount; k++)
				if (vtx[k][0] == v[0] && vtx[k][1] == v[1] && vtx[k][2] == v[2]) begin
					idx = k;
					return 1;
				end
			if (vcount >= VERTEX_DEPTH) return 0;
			for (int k = 0; k < 3; k++) vtx[vcount][k] = v[k];
			idx = vcount;
			vcount++;
			return 1;
		endfunction

		function logic [1:0] build_mesh();
			longint unsigned ca;
			longint unsigned cb;
			int unsigned nf;
			int unsigned a, b, c, ab, bc, ac;
			int s;
			int mg;
			ca = (radius * KA_Q32 + (64'd1 << 31)) >> 32;
			cb = (radius * KB_Q32 + (64'd1 << 31)) >> 32;
			vcount = 0;
			fcount = 0;
			if (radius == 0) return ERR_ZERO_RADIUS;
			for (int i = 0; i < 12; i++)
				for (int k = 0; k < 3; k++) begin
					s = int'(ICO_VERT[i][k]);
					mg = (s == 1 || s == -1) ? int'(ca) : (s == 0 ? 0 : int'(cb));
					vtx[i][k] = (s < 0) ? -mg : mg;
				end
			vcount = 12;
			for (int i = 0; i < 20; i++)
				for (int k = 0; k < 3; k++) fc[i][k] = 32'(ICO_FACE[i][k]);
			fcount = 20;
			for (int lv = 0; lv < levels; lv++) begin
				nf = fcount;
				for (int i = 0; i < nf; i++) begin
					a = fc[i][0];
					b = fc[i][1];
					c = fc[i][2];
					if (!split_edge(a, b, ab)) return ERR_FULL;
					if (!split_edge(c, b, bc)) return ERR_FULL;
					if (!split_edge(a, c, ac)) return ERR_FULL;
					if (fcount + 3 > FACE_DEPTH) return ERR_FULL;
					fc[fcount][0] = a;   fc[fcount][1] = ab;   fc[fcount][2] = ac;
					fc[fcount+1][0] = b; fc[fcount+1][1] = ab; fc[fcount+1][2] = bc;
					fc[fcount+2][0] = c; fc[fcount+2][1] = bc; fc[fcount+2][2] = ac;
					fcount += 3;
					fc[i][0] = ab; fc[i][1] = bc; fc[i][2] = ac;
				end
			end
			return ERR_OK;
		endfunction

		function void set_config(int unsigned rad, int unsigned lv);
			radius = rad & 32'h7FFF_FFFF;
			levels = (lv & 3) > 3 ? 3 : (lv & 3);
		endfunction

		function void note_request(logic [1:0] req, logic [10:0] idx);
			mesh_reply_t e;
			e = '0;
			if (req == REQ_BUILD) begin
				e.err = build_mesh();
			end else if (req == REQ_READ_VERT) begin
				if (idx < vcount) begin
					e.x = vtx[idx][0];
					e.y = vtx[idx][1];
					e.z = vtx[idx][2];
				end else begin
					e.err = ERR_RANGE;
				end
			end else if (req == REQ_READ_FACE) begin
				if (idx < fcount) begin
					e.c1 = 10'(fc[idx][0]);
					e.c2 = 10'(fc[idx][1]);
					e.c3 = 10'(fc[idx][2]);
				end else begin
					e.err = ERR_RANGE;
				end
			end
			e.vtot = 11'(vcount);
			e.ftot = 12'(fcount);
			pending = {pending, e};
		endfunction

		function void cmp_fail(string fld, logic [31:0] exp_v, logic [31:0] act_v);
			$display("%0t: %s expected %h actual %h", $time, fld, exp_v, act_v);
			mismatches++;
		endfunction

		function void check_reply(logic [OUT_W-1:0] data);
			mesh_reply_t got;
			mesh_reply_t e;
			got = mesh_reply_t'(data[OUT_W-2:0]);
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x) cmp_fail("coord_x", e.x, got.x);
			if (got.y !== e.y) cmp_fail("coord_y", e.y, got.y);
			if (got.z !== e.z) cmp_fail("coord_z", e.z, got.z);
			if (got.c1 !== e.c1) cmp_fail("corner_first", 32'(e.c1), 32'(got.c1));
			if (got.c2 !== e.c2) cmp_fail("corner_second", 32'(e.c2), 32'(got.c2));
			if (got.c3 !== e.c3) cmp_fail("corner_third", 32'(e.c3), 32'(got.c3));
			if (got.vtot !== e.vtot) cmp_fail("vertex_total", 32'(e.vtot), 32'(got.vtot));
			if (got.ftot !== e.ftot) cmp_fail("face_total", 32'(e.ftot), 32'(got.ftot));
			if (got.err !== e.err) cmp_fail("error_code", 32'(e.err), 32'(got.err));
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              s_axis_tvalid = 0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;
	logic [1:0]        s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_we = 0;
	logic              cfg_addr = 0;
	logic [RAD_W-1:0]  cfg_wdata = '0;

	mesh_scoreboard sb = new();
	int  send_idle = 0;
	int  recv_stall = 0;
	bit  hold_req = 0;
	int  hold_left = 0;
	int  quiet = 0;

	always #4 clk = ~clk;

	icosphere_mesh_builder_unit dut (.*);

	// receiver: check accepted results, then choose the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
			if (hold_req && hold_left == 0) begin
				hold_left = 400;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_request(logic [1:0] req, logic [10:0] idx);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= req;
		s_axis_tdata <= {5'd0, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(req, idx);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_config(int unsigned rad, int unsigned lv);
		cfg_we <= 1;
		cfg_addr <= REG_RADIUS;
		cfg_wdata <= rad[RAD_W-1:0];
		@(posedge clk);
		cfg_addr <= REG_LEVELS;
		cfg_wdata <= lv[RAD_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
		sb.set_config(rad, lv);
	endtask

	task automatic random_request(int build_pct);
		logic [1:0] req;
		int unsigned lim;
		logic [10:0] idx;
		if ($urandom_range(99) < build_pct) begin
			req = REQ_BUILD;
		end else begin
			req = 2'($urandom_range(3));
			if (req == REQ_BUILD) req = REQ_READ_VERT;
		end
		lim = (req == REQ_READ_FACE) ? sb.fcount : sb.vcount;
		if ($urandom_range(9) < 2 || lim == 0) idx = 11'($urandom);
		else idx = 11'($urandom_range(lim + 1));
		send_request(req, idx);
	endtask

	task automatic run_phase(int items, int unsigned rad, int unsigned lv, int idle_pct,
			int stall_pct);
		drain();
		write_config(rad, lv);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		send_request(REQ_BUILD, 11'($urandom));
		repeat (items) random_request(lv >= 2 ? 0 : 8);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty stores, unused type, default radius build
		send_request(REQ_READ_VERT, 11'd0);
		send_request(REQ_READ_FACE, 11'd0);
		send_request(REQ_NOP, 11'h7FF);
		send_request(REQ_BUILD, 11'd0);
		send_request(REQ_READ_VERT, 11'd0);
		send_request(REQ_READ_VERT, 11'd11);
		send_request(REQ_READ_VERT, 11'd12);
		send_request(REQ_READ_FACE, 11'd19);
		send_request(REQ_READ_FACE, 11'd20);
		send_request(REQ_READ_FACE, 11'h7FF);
		// zero radius
		drain();
		write_config(0, 1);
		send_request(REQ_BUILD, 11'd0);
		send_request(REQ_READ_VERT, 11'd0);
		// largest radius, deepest subdivision
		drain();
		write_config(32'h7FFF_FFFF, 3);
		send_request(REQ_BUILD, 11'd0);
		send_request(REQ_READ_VERT, 11'd641);
		send_request(REQ_READ_VERT, 11'd642);
		send_request(REQ_READ_FACE, 11'd1279);
		send_request(REQ_READ_FACE, 11'd1280);
		send_request(REQ_READ_VERT, 11'd500);
		// tiny radius so midpoints collapse
		drain();
		write_config(1, 2);
		send_request(REQ_BUILD, 11'd0);
		send_request(REQ_READ_VERT, 11'd20);
		send_request(REQ_READ_FACE, 11'd100);

		run_phase(15, $urandom_range(32'h7FFF_FFFF), 1, 0, 0);
		run_phase(15, 65536, 0, 75, 0);
		run_phase(15, $urandom_range(200000, 1), 1, 0, 75);
		run_phase(12, 32'h7FFF_FFFF, 2, 18, 18);
		// long receiver hold-off while requests keep coming
		drain();
		hold_req = 1;
		send_idle = 0;
		repeat (10) random_request(0);
		run_phase(6, $urandom, 0, 0, 0);

		drain();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
